@@ src/bpp_pkg.sv @@
package bpp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned POS_W       = 9;
    localparam int unsigned CFG_IDX_W   = 3;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam logic [POS_W-1:0] POS_SYNC0         = 9'd0;
    localparam logic [POS_W-1:0] POS_SYNC1         = 9'd1;
    localparam logic [POS_W-1:0] POS_LENGTH        = 9'd2;
    localparam logic [POS_W-1:0] FIRST_PAYLOAD_POS = 9'd3;
    localparam int unsigned      VALUE_SLOTS       = 2;

    localparam logic [BYTE_W-1:0] SYNC_CODE_RST     = 8'd170;
    localparam logic [BYTE_W-1:0] EXTENDED_CODE_RST = 8'd85;
    localparam logic [BYTE_W-1:0] QUALITY_CODE_RST  = 8'd2;
    localparam logic [BYTE_W-1:0] HEART_CODE_RST    = 8'd3;
    localparam logic [BYTE_W-1:0] RAW_CODE_RST      = 8'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_CODE     = 3'd0,
        CFG_EXTENDED_CODE = 3'd1,
        CFG_QUALITY_CODE  = 3'd2,
        CFG_HEART_CODE    = 3'd3,
        CFG_RAW_CODE      = 3'd4
    } cfg_idx_e;

    typedef struct packed {
        logic [BYTE_W-1:0] sync_code;
        logic [BYTE_W-1:0] extended_code;
        logic [BYTE_W-1:0] quality_code;
        logic [BYTE_W-1:0] heart_code;
        logic [BYTE_W-1:0] raw_code;
    } cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0]   quality_value;
        logic [BYTE_W-1:0]   heart_value;
        logic [2*BYTE_W-1:0] raw_sample;
        logic                checksum_ok;
    } res_t;

endpackage

@@ src/bpp_cfg_regs.sv @@
module bpp_cfg_regs
    import bpp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_SYNC_CODE:     cfg_next.sync_code     = cfg_wdata;
                CFG_EXTENDED_CODE: cfg_next.extended_code = cfg_wdata;
                CFG_QUALITY_CODE:  cfg_next.quality_code  = cfg_wdata;
                CFG_HEART_CODE:    cfg_next.heart_code    = cfg_wdata;
                CFG_RAW_CODE:      cfg_next.raw_code      = cfg_wdata;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sync_code     <= SYNC_CODE_RST;
            cfg_reg.extended_code <= EXTENDED_CODE_RST;
            cfg_reg.quality_code  <= QUALITY_CODE_RST;
            cfg_reg.heart_code    <= HEART_CODE_RST;
            cfg_reg.raw_code      <= RAW_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/bpp_parser.sv @@
module bpp_parser
    import bpp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cfg_t              cfg,
    input  logic              step,
    input  logic [BYTE_W-1:0] byte_in,
    output logic              res_valid,
    output res_t              res
);

    logic [POS_W-1:0]    frame_count_reg,       frame_count_next;
    logic [BYTE_W-1:0]   payload_length_reg,    payload_length_next;
    logic                expect_code_reg,       expect_code_next;
    logic                expect_row_length_reg, expect_row_length_next;
    logic [BYTE_W-1:0]   row_code_reg,          row_code_next;
    logic [BYTE_W-1:0]   row_length_reg,        row_length_next;
    logic [BYTE_W-1:0]   row_index_reg,         row_index_next;
    logic [BYTE_W-1:0]   running_sum_reg,       running_sum_next;
    logic [BYTE_W-1:0]   value_bytes_reg [VALUE_SLOTS];
    logic [BYTE_W-1:0]   value_bytes_next [VALUE_SLOTS];
    logic [BYTE_W-1:0]   held_quality_reg,      held_quality_next;
    logic [BYTE_W-1:0]   held_heart_reg,        held_heart_next;
    logic [2*BYTE_W-1:0] held_raw_reg,          held_raw_next;

    logic [POS_W-1:0]  payload_pos;
    logic              in_payload;
    logic [BYTE_W-1:0] row_index_inc;
    logic [BYTE_W-1:0] sum_add;

    assign payload_pos   = frame_count_reg - FIRST_PAYLOAD_POS;
    assign in_payload    = (payload_pos < {1'b0, payload_length_reg});
    assign row_index_inc = row_index_reg + 8'd1;
    assign sum_add       = running_sum_reg + byte_in;

    always_comb
    begin
        frame_count_next       = frame_count_reg;
        payload_length_next    = payload_length_reg;
        expect_code_next       = expect_code_reg;
        expect_row_length_next = expect_row_length_reg;
        row_code_next          = row_code_reg;
        row_length_next        = row_length_reg;
        row_index_next         = row_index_reg;
        running_sum_next       = running_sum_reg;
        value_bytes_next       = value_bytes_reg;
        held_quality_next      = held_quality_reg;
        held_heart_next        = held_heart_reg;
        held_raw_next          = held_raw_reg;
        res_valid              = 1'b0;

        if (step)
        begin
            if (frame_count_reg == POS_SYNC0 || frame_count_reg == POS_SYNC1)
            begin
                if (byte_in != cfg.sync_code)
                begin
                    frame_count_next = POS_SYNC0;
                end
                else
                begin
                    frame_count_next = frame_count_reg + 9'd1;
                end
            end
            else if (frame_count_reg == POS_LENGTH)
            begin
                payload_length_next = byte_in;
                expect_code_next    = 1'b1;
                frame_count_next    = frame_count_reg + 9'd1;
            end
            else if (in_payload)
            begin
                frame_count_next = frame_count_reg + 9'd1;
                if (byte_in == cfg.extended_code)
                begin
                    expect_code_next = 1'b1;
                    running_sum_next = sum_add;
                end
                else if (expect_code_reg)
                begin
                    row_code_next    = byte_in;
                    expect_code_next = 1'b0;
                    running_sum_next = sum_add;
                    row_index_next   = '0;
                    if (byte_in == cfg.quality_code || byte_in == cfg.heart_code)
                    begin
                        row_length_next        = 8'd1;
                        expect_row_length_next = 1'b0;
                    end
                    else if (byte_in == cfg.raw_code)
                    begin
                        expect_row_length_next = 1'b1;
                    end
                    else
                    begin
                        // abandon the packet
                        row_index_next   = row_index_reg;
                        frame_count_next = POS_SYNC0;
                        running_sum_next = '0;
                    end
                end
                else if (expect_row_length_reg)
                begin
                    row_length_next        = byte_in;
                    expect_row_length_next = 1'b0;
                    running_sum_next       = sum_add;
                end
                else if (row_index_reg < row_length_reg)
                begin
                    if (row_index_reg < 8'd2)
                    begin
                        value_bytes_next[row_index_reg[0]] = byte_in;
                    end
                    row_index_next   = row_index_inc;
                    running_sum_next = sum_add;
                    if (row_index_inc == row_length_reg)
                    begin
                        expect_code_next = 1'b1;
                        if (row_code_reg == cfg.quality_code)
                        begin
                            held_quality_next = value_bytes_next[0];
                        end
                        else if (row_code_reg == cfg.heart_code)
                        begin
                            held_heart_next = value_bytes_next[0];
                        end
                        else if (row_code_reg == cfg.raw_code)
                        begin
                            held_raw_next = {value_bytes_next[0], value_bytes_next[1]};
                        end
                    end
                end
            end
            else
            begin
                res_valid        = 1'b1;
                running_sum_next = '0;
                frame_count_next = POS_SYNC0;
                row_index_next   = '0;
            end
        end
    end

    assign res.quality_value = held_quality_reg;
    assign res.heart_value   = held_heart_reg;
    assign res.raw_sample    = held_raw_reg;
    assign res.checksum_ok   = (~running_sum_reg == byte_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg       <= '0;
            payload_length_reg    <= '0;
            expect_code_reg       <= 1'b0;
            expect_row_length_reg <= 1'b0;
            row_code_reg          <= '0;
            row_length_reg        <= '0;
            row_index_reg         <= '0;
            running_sum_reg       <= '0;
            value_bytes_reg[0]    <= '0;
            value_bytes_reg[1]    <= '0;
            held_quality_reg      <= '0;
            held_heart_reg        <= '0;
            held_raw_reg          <= '0;
        end
        else
        begin
            frame_count_reg       <= frame_count_next;
            payload_length_reg    <= payload_length_next;
            expect_code_reg       <= expect_code_next;
            expect_row_length_reg <= expect_row_length_next;
            row_code_reg          <= row_code_next;
            row_length_reg        <= row_length_next;
            row_index_reg         <= row_index_next;
            running_sum_reg       <= running_sum_next;
            value_bytes_reg       <= value_bytes_next;
            held_quality_reg      <= held_quality_next;
            held_heart_reg        <= held_heart_next;
            held_raw_reg          <= held_raw_next;
        end
    end

endmodule

@@ src/bpp_out_reg.sv @@
module bpp_out_reg
    import bpp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic load,
    input  res_t res_in,
    input  logic out_ready,
    output logic out_valid,
    output logic can_load,
    output res_t res_out
);

    logic out_valid_reg, out_valid_next;
    res_t res_reg, res_next;

    assign can_load = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        res_next       = res_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            res_next       = res_in;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign out_valid = out_valid_reg;
    assign res_out   = res_reg;

endmodule

@@ src/biosensor_packet_parser_top.sv @@
// Sync-framed sensor packet parser. Takes one received byte per cycle on the
// input channel and follows the framing (two sync bytes, length, rows, checksum);
// only the checksum byte produces a transaction on the output channel, carrying
// the held quality, heart-rate and raw values and the checksum pass flag.
// A byte goes into an input register and, once the output register can take a
// result, is parsed by one pass of logic that updates the packet state; the
// result of a checksum byte lands in the output register. Sustained rate is one
// byte per cycle while the output is not stalled. A result waiting unaccepted in
// the output register holds the input register's byte and, once that register is
// full, stalls the input channel. Codes are set through the write port; the user
// must ensure they are changed only while idle; the block does not enforce this.
module biosensor_packet_parser_top
    import bpp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [BYTE_W-1:0]     rx_byte,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [BYTE_W-1:0]     quality_value,
    output logic [BYTE_W-1:0]     heart_value,
    output logic signed [2*BYTE_W-1:0] raw_sample,
    output logic                  checksum_ok
);

    cfg_t              cfg;
    res_t              res;
    res_t              res_out;
    logic              res_valid;
    logic              can_load;
    logic              step;
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;

    assign step     = in_valid_reg && can_load;
    assign in_ready = !in_valid_reg || can_load;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        byte_next     = byte_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            byte_next     = rx_byte;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    bpp_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bpp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .step      (step),
        .byte_in   (byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    bpp_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_valid),
        .res_in    (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .can_load  (can_load),
        .res_out   (res_out)
    );

    assign quality_value = res_out.quality_value;
    assign heart_value   = res_out.heart_value;
    assign raw_sample    = signed'(res_out.raw_sample);
    assign checksum_ok   = res_out.checksum_ok;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !can_load) |=> (in_valid_reg && $stable(byte_reg)))
        else $error("input register lost a stalled byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> (!out_valid || out_ready))
        else $error("result overwrote a pending transaction");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |=> out_valid)
        else $error("result not presented after checksum byte");

    a_result_from_byte: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> step)
        else $error("result produced without a byte in process");

endmodule
